/* rtl/kdlp_pkg.sv */
// shared types and constants for the key debounce and long-press block
package kdlp_pkg;

  // field and register widths
  localparam int unsigned DEB_W   = 8;
  localparam int unsigned LONG_W  = 16;
  localparam int unsigned EVENT_W = 3;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // register reset values
  localparam logic [DEB_W-1:0]  DEB_TICKS_RST  = 8'd10;
  localparam logic [LONG_W-1:0] LONG_TICKS_RST = 16'd3000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEB_TICKS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS = 1'b1;

  // event codes
  localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
  localparam logic [EVENT_W-1:0] EV_DOWN    = 3'd1;
  localparam logic [EVENT_W-1:0] EV_UP      = 3'd2;
  localparam logic [EVENT_W-1:0] EV_LONG    = 3'd3;
  localparam logic [EVENT_W-1:0] EV_LONG_UP = 3'd4;

  // press classifier phases
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_HELD = 3'b010,
    PH_LONG = 3'b100
  } phase_t;

endpackage

/* rtl/key_debounce_long_press_top.sv */
// key debounce with press, release and long-press event reporting
//
// Usage: each input item is one tick carrying the sampled button level on
// in_raw_level. Every tick gives exactly one result item: the debounced
// level, an event code (none, down, up, long, long release) and a
// long-release flag. Down and long codes hold while pressed; idle gives none.
// Both channels use valid/stall; an item moves when valid is high and
// stall is low. cfg_wr_en writes register cfg_index (0 debounce ticks,
// 1 long-press ticks) with cfg_wr_data; write only while the block is idle.
// Stages: two register stages (input register, then the debounce/classify
// update into the result register); an accepted item moves on into the
// result register once that register is empty or out_stall is low.
// Throughput: one item per cycle unless stalled; one update stage sets this.
// Reset (rst_n low, synchronous) clears both stages, returns the level to
// released, the classifier to idle, counters to zero and the registers to
// their defaults (10 and 3000).
// When out_stall is high with a result waiting, the result holds; the input
// register can still take one item, after which in_stall rises.
module key_debounce_long_press_top #(
  parameter int unsigned HOLD_COUNT_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_raw_level,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_clean_level,
  output logic [kdlp_pkg::EVENT_W-1:0]     out_key_event,
  output logic                             out_long_release,
  // configuration port
  input  logic                             cfg_wr_en,
  input  logic [kdlp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kdlp_pkg::CFG_W-1:0]       cfg_wr_data
);

  localparam int unsigned CMP_W =
    (HOLD_COUNT_BITS > kdlp_pkg::LONG_W) ? HOLD_COUNT_BITS : kdlp_pkg::LONG_W;

  // configuration registers
  logic [kdlp_pkg::DEB_W-1:0]  deb_ticks_r;
  logic [kdlp_pkg::LONG_W-1:0] long_ticks_r;

  // input stage
  logic s1_valid_r, s1_valid_nxt;
  logic s1_raw_r;

  // tick state
  logic                        stable_r, stable_nxt;
  logic [kdlp_pkg::DEB_W-1:0]  mis_cnt_r, mis_cnt_nxt, mis_inc;
  kdlp_pkg::phase_t            phase_r, phase_nxt;
  logic [HOLD_COUNT_BITS-1:0]  hold_cnt_r, hold_cnt_nxt, hold_inc;
  logic [kdlp_pkg::EVENT_W-1:0] event_r, event_nxt;

  // result stage
  logic out_valid_r, out_valid_nxt;
  logic out_level_r;
  logic [kdlp_pkg::EVENT_W-1:0] out_event_r;
  logic out_long_rel_r;

  logic adv, in_acc, step;

  // handshake control
  assign adv      = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  assign s1_valid_nxt  = in_acc || (s1_valid_r && !adv);
  assign out_valid_nxt = step || (out_valid_r && out_stall);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_ticks_r  <= kdlp_pkg::DEB_TICKS_RST;
      long_ticks_r <= kdlp_pkg::LONG_TICKS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        kdlp_pkg::CFG_DEB_TICKS: begin
          deb_ticks_r <= cfg_wr_data[kdlp_pkg::DEB_W-1:0];
        end
        kdlp_pkg::CFG_LONG_TICKS: begin
          long_ticks_r <= cfg_wr_data[kdlp_pkg::LONG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // debounce: saturating mismatch count, level flips once it exceeds the limit
  always_comb begin
    mis_inc     = (mis_cnt_r == '1) ? mis_cnt_r : mis_cnt_r + 1'b1;
    stable_nxt  = stable_r;
    mis_cnt_nxt = '0;
    if (s1_raw_r != stable_r) begin
      if (mis_inc > deb_ticks_r) begin
        stable_nxt = s1_raw_r;
      end else begin
        mis_cnt_nxt = mis_inc;
      end
    end
  end

  // press classifier on the debounced level
  always_comb begin
    hold_inc     = (hold_cnt_r == '1) ? hold_cnt_r : hold_cnt_r + 1'b1;
    phase_nxt    = phase_r;
    hold_cnt_nxt = hold_cnt_r;
    event_nxt    = event_r;
    case (phase_r)
      kdlp_pkg::PH_HELD: begin
        if (stable_nxt) begin
          hold_cnt_nxt = hold_inc;
          if (CMP_W'(hold_inc) >= CMP_W'(long_ticks_r)) begin
            event_nxt = kdlp_pkg::EV_LONG;
            phase_nxt = kdlp_pkg::PH_LONG;
          end
        end else begin
          event_nxt = kdlp_pkg::EV_UP;
          phase_nxt = kdlp_pkg::PH_IDLE;
        end
      end
      kdlp_pkg::PH_LONG: begin
        if (!stable_nxt) begin
          event_nxt = kdlp_pkg::EV_LONG_UP;
          phase_nxt = kdlp_pkg::PH_IDLE;
        end
      end
      default: begin
        if (stable_nxt) begin
          hold_cnt_nxt = '0;
          phase_nxt    = kdlp_pkg::PH_HELD;
          event_nxt    = kdlp_pkg::EV_DOWN;
        end else begin
          phase_nxt = kdlp_pkg::PH_IDLE;
          event_nxt = kdlp_pkg::EV_NONE;
        end
      end
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      stable_r    <= 1'b0;
      mis_cnt_r   <= '0;
      phase_r     <= kdlp_pkg::PH_IDLE;
      hold_cnt_r  <= '0;
      event_r     <= kdlp_pkg::EV_NONE;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (step) begin
        stable_r   <= stable_nxt;
        mis_cnt_r  <= mis_cnt_nxt;
        phase_r    <= phase_nxt;
        hold_cnt_r <= hold_cnt_nxt;
        event_r    <= event_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_raw_r <= in_raw_level;
    end
    if (step) begin
      out_level_r    <= stable_nxt;
      out_event_r    <= event_nxt;
      out_long_rel_r <= (event_nxt == kdlp_pkg::EV_LONG_UP);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_clean_level  = out_level_r;
  assign out_key_event    = out_event_r;
  assign out_long_release = out_long_rel_r;

  // checks
  a_long_rel_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_long_release == (out_key_event == kdlp_pkg::EV_LONG_UP)))
    else $error("long release flag disagrees with event code");

  a_down_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_key_event == kdlp_pkg::EV_DOWN ||
                   out_key_event == kdlp_pkg::EV_LONG)) |-> out_clean_level)
    else $error("press event reported with released level");

  a_up_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_key_event == kdlp_pkg::EV_UP ||
                   out_key_event == kdlp_pkg::EV_LONG_UP ||
                   out_key_event == kdlp_pkg::EV_NONE)) |-> !out_clean_level)
    else $error("release event reported with pressed level");

  a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |=> s1_valid_r)
    else $error("input stage item lost during output stall");

endmodule

/* test/key_debounce_long_press_checker.sv */
// checker for the key debounce block: predicts every tick result and compares it
`timescale 1ns / 100ps

module key_debounce_long_press_checker #(
  parameter int unsigned HOLD_COUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           in_raw_level,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           out_clean_level,
  input  logic [kdlp_pkg::EVENT_W-1:0]   out_key_event,
  input  logic                           out_long_release,
  input  logic                           cfg_wr_en,
  input  logic [kdlp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kdlp_pkg::CFG_W-1:0]     cfg_wr_data,
  output int                             outstanding,
  output int                             fail_count
);

  typedef struct packed {
    logic                         clean_level;
    logic [kdlp_pkg::EVENT_W-1:0] key_event;
    logic                         long_release;
  } key_result_t;

  key_result_t key_results_q[$];

  // register copies
  logic [kdlp_pkg::DEB_W-1:0]  deb_ticks;
  logic [kdlp_pkg::LONG_W-1:0] long_ticks;

  // predicted key state
  logic                         stable_lvl;
  logic [7:0]                   mismatch_cnt;
  kdlp_pkg::phase_t             phase_q;
  logic [HOLD_COUNT_BITS-1:0]   hold_cnt;
  logic [kdlp_pkg::EVENT_W-1:0] event_q;

  // one line per mismatch
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // debounce one tick, classify the clean level, queue the expected result
  task automatic debounce_and_classify(input logic raw);
    key_result_t res;
    if (raw != stable_lvl) begin
      if (mismatch_cnt != 8'hFF) mismatch_cnt++;
      if (mismatch_cnt > deb_ticks) begin
        stable_lvl   = raw;
        mismatch_cnt = '0;
      end
    end else begin
      mismatch_cnt = '0;
    end

    case (phase_q)
      kdlp_pkg::PH_HELD: begin
        if (stable_lvl) begin
          if (hold_cnt != {HOLD_COUNT_BITS{1'b1}}) hold_cnt++;
          if (32'(hold_cnt) >= 32'(long_ticks)) begin
            event_q = kdlp_pkg::EV_LONG;
            phase_q = kdlp_pkg::PH_LONG;
          end
        end else begin
          event_q = kdlp_pkg::EV_UP;
          phase_q = kdlp_pkg::PH_IDLE;
        end
      end
      kdlp_pkg::PH_LONG: begin
        if (!stable_lvl) begin
          event_q = kdlp_pkg::EV_LONG_UP;
          phase_q = kdlp_pkg::PH_IDLE;
        end
      end
      default: begin
        if (stable_lvl) begin
          hold_cnt = '0;
          phase_q  = kdlp_pkg::PH_HELD;
          event_q  = kdlp_pkg::EV_DOWN;
        end else begin
          phase_q = kdlp_pkg::PH_IDLE;
          event_q = kdlp_pkg::EV_NONE;
        end
      end
    endcase

    res.clean_level  = stable_lvl;
    res.key_event    = event_q;
    res.long_release = (event_q == kdlp_pkg::EV_LONG_UP);
    key_results_q.push_back(res);
  endtask

  // watch reset, register writes and both channels
  always @(posedge clk) begin
    key_result_t want;
    if (!rst_n) begin
      fail_count   = 0;
      deb_ticks    = kdlp_pkg::DEB_TICKS_RST;
      long_ticks   = kdlp_pkg::LONG_TICKS_RST;
      stable_lvl   = 1'b0;
      mismatch_cnt = '0;
      phase_q      = kdlp_pkg::PH_IDLE;
      hold_cnt     = '0;
      event_q      = kdlp_pkg::EV_NONE;
      key_results_q.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == kdlp_pkg::CFG_DEB_TICKS) begin
          deb_ticks = cfg_wr_data[kdlp_pkg::DEB_W-1:0];
        end else if (cfg_index == kdlp_pkg::CFG_LONG_TICKS) begin
          long_ticks = cfg_wr_data[kdlp_pkg::LONG_W-1:0];
        end
      end

      // results leave before this edge's item is predicted
      if (out_valid && !out_stall) begin
        if (key_results_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", int'(out_key_event), 0);
        end else begin
          want = key_results_q.pop_front();
          if (out_clean_level !== want.clean_level)
            report_mismatch("clean_level", int'(out_clean_level), int'(want.clean_level));
          if (out_key_event !== want.key_event)
            report_mismatch("key_event", int'(out_key_event), int'(want.key_event));
          if (out_long_release !== want.long_release)
            report_mismatch("long_release", int'(out_long_release),
                            int'(want.long_release));
        end
      end

      if (in_valid && !in_stall) debounce_and_classify(in_raw_level);
    end
    outstanding <= key_results_q.size();
  end

endmodule

/* test/testbench.sv */
// top of the key debounce testbench: clock, reset, tick stimulus, register writes and verdict
`timescale 1ns / 100ps

module testbench;

  logic                           clk          = 1'b0;
  logic                           rst_n        = 1'b0;
  logic                           in_valid     = 1'b0;
  logic                           in_raw_level = 1'b0;
  logic                           out_stall    = 1'b0;
  logic                           cfg_wr_en    = 1'b0;
  logic [kdlp_pkg::CFG_IDX_W-1:0] cfg_index    = kdlp_pkg::CFG_DEB_TICKS;
  logic [kdlp_pkg::CFG_W-1:0]     cfg_wr_data  = '0;

  logic                         in_stall;
  logic                         out_valid;
  logic                         out_clean_level;
  logic [kdlp_pkg::EVENT_W-1:0] out_key_event;
  logic                         out_long_release;

  int outstanding;
  int fail_count;
  int ticks_sent  = 0;
  bit calm        = 1'b0;
  bit holdoff_req = 1'b0;

  key_debounce_long_press_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_raw_level     (in_raw_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_clean_level  (out_clean_level),
    .out_key_event    (out_key_event),
    .out_long_release (out_long_release),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data)
  );

  key_debounce_long_press_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_raw_level     (in_raw_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_clean_level  (out_clean_level),
    .out_key_event    (out_key_event),
    .out_long_release (out_long_release),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data),
    .outstanding      (outstanding),
    .fail_count       (fail_count)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    #10ms;
    $display("testbench failed");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 11);
    end
  end

  // offer one tick item, with random idle cycles ahead of it
  task automatic send_tick(input logic lvl);
    while (!calm && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_raw_level <= lvl;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
  endtask

  task automatic hold_level(input logic lvl, input int n);
    for (int k = 0; k < n; k++) send_tick(lvl);
  endtask

  // stop sending and wait until every tick has produced its result
  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (outstanding != 0 && waited < 5000);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_register(input logic [kdlp_pkg::CFG_IDX_W-1:0] idx,
                              input int unsigned val);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= kdlp_pkg::CFG_W'(val);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // mostly clean presses (bounce, then a short or long hold, then release) with some noise
  task automatic press_sequences(input int n_items, input int deb, input int lng);
    int   stop_at;
    int   len;
    logic lvl;
    stop_at = ticks_sent + n_items;
    lvl     = 1'b1;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 99) < 15) begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) send_tick(1'($urandom_range(0, 1)));
      end else begin
        len = $urandom_range(0, deb + 1);
        for (int k = 0; k < len; k++) send_tick(1'($urandom_range(0, 1)));
        if (lvl && $urandom_range(0, 1)) len = $urandom_range(deb + lng + 2, deb + lng + 20);
        else len = $urandom_range(deb + 2, deb + lng + 1);
        hold_level(lvl, len);
        lvl = !lvl;
      end
    end
  endtask

  task automatic random_phase(input int deb, input int lng, input int n_items);
    drain_results();
    set_register(kdlp_pkg::CFG_DEB_TICKS, deb);
    set_register(kdlp_pkg::CFG_LONG_TICKS, lng);
    press_sequences(n_items, deb, lng);
  endtask

  initial begin
    int deb;
    int lng;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: a glitch shorter than the window, then a real press and release
    hold_level(1'b1, 5);
    hold_level(1'b0, 2);
    hold_level(1'b1, 14);
    hold_level(1'b0, 13);

    // no debounce and a long press of zero: down, long, long release, then a short press
    drain_results();
    set_register(kdlp_pkg::CFG_DEB_TICKS, 0);
    set_register(kdlp_pkg::CFG_LONG_TICKS, 0);
    hold_level(1'b1, 3);
    hold_level(1'b0, 2);
    hold_level(1'b1, 1);
    hold_level(1'b0, 2);

    // maximum debounce: the saturated mismatch count never lets the level change
    drain_results();
    set_register(kdlp_pkg::CFG_DEB_TICKS, 255);
    set_register(kdlp_pkg::CFG_LONG_TICKS, 1);
    hold_level(1'b1, 300);
    hold_level(1'b0, 3);

    // maximum long press: a press far shorter than the limit stays a short press
    drain_results();
    set_register(kdlp_pkg::CFG_DEB_TICKS, 0);
    set_register(kdlp_pkg::CFG_LONG_TICKS, 16'hFFFF);
    hold_level(1'b1, 200);
    hold_level(1'b0, 3);

    // random presses over several settings; the first runs with no idling at all
    calm = 1'b1;
    random_phase($urandom_range(0, 6), $urandom_range(1, 40), 220);
    calm = 1'b0;

    deb = $urandom_range(0, 6);
    lng = $urandom_range(1, 40);
    drain_results();
    set_register(kdlp_pkg::CFG_DEB_TICKS, deb);
    set_register(kdlp_pkg::CFG_LONG_TICKS, lng);
    holdoff_req = 1'b1;
    press_sequences(220, deb, lng);

    // sender pauses midway until every result is back
    random_phase(3, 1, 110);
    drain_results();
    press_sequences(110, 3, 1);

    random_phase(1, 2, 220);
    random_phase($urandom_range(0, 10), $urandom_range(1, 60), 220);

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
